// ===== rtl/lmd_pkg.sv =====
// Package for the LED matrix frame driver: command codes, state and plan types,
// driver register addresses and the init word table. No dependencies.
`default_nettype none

package lmd_pkg;

  typedef enum logic [2:0] {
    OP_INIT   = 3'd0,
    OP_ON     = 3'd1,
    OP_OFF    = 3'd2,
    OP_TOGGLE = 3'd3,
    OP_ROW    = 3'd4,
    OP_COL    = 3'd5,
    OP_CLEAR  = 3'd6,
    OP_FILL   = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    CLS_ERR,
    CLS_INIT,
    CLS_PIX,
    CLS_SWEEP
  } cls_e;

  typedef enum logic [1:0] {
    KIND_BIT,
    KIND_BYTE,
    KIND_ALL
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_INIT,
    S_PEEK,
    S_TEST,
    S_SWEEP,
    S_DRAIN
  } state_e;

  typedef struct packed {
    kind_e      kind;
    logic       full;
    logic [2:0] digit;
    logic [2:0] bitpos;
    logic       level;
    logic       use_pat;
    logic       flip;
  } plan_t;

  localparam logic [3:0] REG_DIGIT0    = 4'd1;
  localparam logic [3:0] REG_DECODE    = 4'd9;
  localparam logic [3:0] REG_INTENSITY = 4'd10;
  localparam logic [3:0] REG_SCANLIMIT = 4'd11;
  localparam logic [3:0] REG_SHUTDOWN  = 4'd12;
  localparam logic [3:0] REG_TEST      = 4'd15;

  localparam logic [7:0] SCAN_ALL  = 8'h07;
  localparam logic [7:0] NO_DECODE = 8'h00;
  localparam logic [7:0] NORMAL_OP = 8'h01;
  localparam logic [7:0] TEST_OFF  = 8'h00;

  localparam logic [2:0] INIT_LAST_STEP = 3'd4;

  localparam logic CFG_ROTATION   = 1'b0;
  localparam logic CFG_BRIGHTNESS = 1'b1;

  localparam logic [3:0] BRIGHT_RESET = 4'h1;

  function automatic logic [3:0] init_reg(logic [2:0] step);
    logic [3:0] r;
    case (step)
      3'd0:    r = REG_SCANLIMIT;
      3'd1:    r = REG_DECODE;
      3'd2:    r = REG_SHUTDOWN;
      3'd3:    r = REG_TEST;
      default: r = REG_INTENSITY;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] init_data(logic [2:0] step, logic [3:0] bright);
    logic [7:0] d;
    case (step)
      3'd0:    d = SCAN_ALL;
      3'd1:    d = NO_DECODE;
      3'd2:    d = NORMAL_OP;
      3'd3:    d = TEST_OFF;
      default: d = {4'h0, bright};
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lmd_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none

module lmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/lmd_decode.sv =====
// Command decoder: range check and mapping of logical coordinates to unit, digit
// line and bit for the current rotation. Depends on lmd_pkg.
`default_nettype none

module lmd_decode import lmd_pkg::*; #(
  parameter int UNITS = 4
) (
  input  wire op_e                                    op_i,
  input  wire logic [4:0]                             x_i,
  input  wire logic [4:0]                             y_i,
  input  wire logic [1:0]                             rot_i,
  output cls_e                                        cls_o,
  output plan_t                                       plan_o,
  output logic [((UNITS > 1) ? $clog2(UNITS) : 1)-1:0] unit_o
);

  localparam int LineCount = 8 * UNITS;
  localparam int UnitW = (UNITS > 1) ? $clog2(UNITS) : 1;
  localparam int UxW = UnitW + 2;
  localparam int CmpW = ($clog2(LineCount + 1) > 5) ? $clog2(LineCount + 1) : 6;

  logic [4:0]      xe;
  logic [4:0]      ye;
  logic [CmpW-1:0] w_len;
  logic [CmpW-1:0] h_len;
  logic            x_ok;
  logic            y_ok;
  logic [UxW-1:0]  xhi;
  logic [UxW-1:0]  yhi;
  logic [UxW-1:0]  units_m1;
  logic [UxW-1:0]  uext;
  logic [2:0]      dig;
  logic [2:0]      bpos;

  always_comb begin
    xe = (op_i == OP_ROW) ? 5'd0 : x_i;
    ye = (op_i == OP_COL) ? 5'd0 : y_i;
    w_len = rot_i[0] ? CmpW'(8) : CmpW'(LineCount);
    h_len = rot_i[0] ? CmpW'(LineCount) : CmpW'(8);
    x_ok = CmpW'(x_i) < w_len;
    y_ok = CmpW'(y_i) < h_len;
    xhi = {{UnitW{1'b0}}, xe[4:3]};
    yhi = {{UnitW{1'b0}}, ye[4:3]};
    units_m1 = UxW'(UNITS - 1);
    case (rot_i)
      2'd0: begin
        uext = xhi;
        dig  = ye[2:0];
        bpos = 3'd7 - xe[2:0];
      end
      2'd1: begin
        uext = units_m1 - yhi;
        dig  = xe[2:0];
        bpos = ye[2:0];
      end
      2'd2: begin
        uext = units_m1 - xhi;
        dig  = 3'd7 - ye[2:0];
        bpos = xe[2:0];
      end
      default: begin
        uext = yhi;
        dig  = 3'd7 - xe[2:0];
        bpos = 3'd7 - ye[2:0];
      end
    endcase
  end

  assign unit_o = uext[UnitW-1:0];

  always_comb begin
    plan_o = '0;
    plan_o.kind = KIND_ALL;
    cls_o = CLS_ERR;
    case (op_i)
      OP_INIT: begin
        cls_o = CLS_INIT;
      end
      OP_ON, OP_OFF, OP_TOGGLE: begin
        cls_o = (x_ok && y_ok) ? CLS_PIX : CLS_ERR;
        plan_o.kind = KIND_BIT;
        plan_o.digit = dig;
        plan_o.bitpos = bpos;
      end
      OP_ROW, OP_COL: begin
        if (op_i == OP_ROW) begin
          cls_o = y_ok ? CLS_SWEEP : CLS_ERR;
        end else begin
          cls_o = x_ok ? CLS_SWEEP : CLS_ERR;
        end
        if (rot_i[0] == (op_i == OP_ROW)) begin
          plan_o.kind = KIND_BIT;
          plan_o.full = 1'b1;
          plan_o.bitpos = bpos;
          plan_o.use_pat = 1'b1;
          plan_o.flip = rot_i[1];
        end else begin
          plan_o.kind = KIND_BYTE;
          plan_o.digit = dig;
          plan_o.flip = rot_i[0] ^ rot_i[1];
        end
      end
      OP_CLEAR: begin
        cls_o = CLS_SWEEP;
        plan_o.full = 1'b1;
      end
      OP_FILL: begin
        cls_o = CLS_SWEEP;
        plan_o.full = 1'b1;
        plan_o.level = 1'b1;
      end
      default: begin
        cls_o = CLS_ERR;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/lmd_merge.sv =====
// Line merge: computes the new value of one native line from its old value and
// the latched command plan. Depends on lmd_pkg.
`default_nettype none

module lmd_merge import lmd_pkg::*; #(
  parameter int UNITS = 4
) (
  input  wire plan_t                                       plan_i,
  input  wire logic [((UNITS > 1) ? $clog2(UNITS) : 1)-1:0] target_i,
  input  wire logic [((UNITS > 1) ? $clog2(UNITS) : 1)-1:0] unit_i,
  input  wire logic [2:0]                                  digit_i,
  input  wire logic [31:0]                                 pattern_i,
  input  wire logic [7:0]                                  old_i,
  output logic      [7:0]                                  new_o
);

  localparam int UnitW = (UNITS > 1) ? $clog2(UNITS) : 1;
  localparam int UxW = UnitW + 2;

  logic [7:0]     pat_lo;
  logic           sel;
  logic [7:0]     mask;
  logic [7:0]     val;
  logic [UxW-1:0] r_ext;
  logic [7:0]     byte_v;
  logic [7:0]     byte_rev;

  always_comb begin
    pat_lo = pattern_i[7:0];
    sel = plan_i.level;
    if (plan_i.use_pat) begin
      sel = plan_i.flip ? pat_lo[digit_i] : pat_lo[3'd7 - digit_i];
    end
    r_ext = plan_i.flip ? {2'b00, unit_i} : UxW'(UNITS - 1) - {2'b00, unit_i};
    case (r_ext[1:0])
      2'd0:    byte_v = pattern_i[7:0];
      2'd1:    byte_v = pattern_i[15:8];
      2'd2:    byte_v = pattern_i[23:16];
      default: byte_v = pattern_i[31:24];
    endcase
    if (r_ext >= UxW'(4)) begin
      byte_v = 8'h00;
    end
    for (int i = 0; i < 8; i++) begin
      byte_rev[i] = byte_v[7 - i];
    end
    case (plan_i.kind)
      KIND_BIT: begin
        mask = (unit_i == target_i) ? (8'b1 << plan_i.bitpos) : 8'h00;
        val  = {8{sel}};
      end
      KIND_BYTE: begin
        mask = 8'hFF;
        val  = plan_i.flip ? byte_rev : byte_v;
      end
      default: begin
        mask = 8'hFF;
        val  = {8{plan_i.level}};
      end
    endcase
    new_o = (old_i & ~mask) | (val & mask);
  end

endmodule

`default_nettype wire

// ===== rtl/led_matrix_frame_driver_unit.sv =====
// Top level of the LED matrix frame driver: sequencer, frame buffer RAM, config
// registers and output register. Depends on lmd_pkg, lmd_ram, lmd_decode, lmd_merge.
//
// A command beat is taken when start is high and busy is low. Each command
// produces zero or more driver words; each word is shown on the result ports for
// one cycle with strobe_o high, and the receiver cannot stall them.
// The frame buffer (8*UNITS lines) sits in one RAM with a registered read and is
// updated read-modify-write, one line per cycle, as its words are sent.
// A clear, fill or cross-line row or column refreshes the whole frame; a single-line
// row or column, or a pixel that changes, sends one digit line to every unit. An
// error or init sends its words straight from the sequencer; a pixel first reads its
// line and tests the bit, and sends nothing when the pixel is already in the asked
// state. Line words then follow one per cycle, paced by the single RAM read port.
// Reset clears the frame to zero through per-line valid bits, sets rotation to
// 0 and brightness to 1. Configuration writes take effect at once.
`default_nettype none

module led_matrix_frame_driver_unit import lmd_pkg::*; #(
  parameter int UNITS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  op_i,
  input  wire logic [4:0]  x_pos_i,
  input  wire logic [4:0]  y_pos_i,
  input  wire logic [31:0] pattern_i,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [3:0]  cfg_wdata_i,
  output logic             strobe_o,
  output logic [3:0]       word_reg_o,
  output logic [7:0]       word_data_o,
  output logic             load_after_o,
  output logic             range_error_o
);

  localparam int LineCount = 8 * UNITS;
  localparam int RamAw = $clog2(LineCount);
  localparam int UnitW = (UNITS > 1) ? $clog2(UNITS) : 1;

  state_e state_q, state_d;

  logic [1:0] rot_q;
  logic [3:0] bright_q;

  cls_e             dec_cls;
  plan_t            dec_plan;
  logic [UnitW-1:0] dec_unit;

  plan_t            plan_q, plan_d;
  logic [UnitW-1:0] tu_q, tu_d;
  logic [31:0]      pattern_q, pattern_d;
  op_e              op_q, op_d;
  logic [UnitW-1:0] cnt_u_q, cnt_u_d;
  logic [2:0]       cnt_d_q, cnt_d_d;

  logic             pipe_vld_q, pipe_vld_d;
  logic [UnitW-1:0] pipe_u_q, pipe_u_d;
  logic [2:0]       pipe_dig_q, pipe_dig_d;

  logic [LineCount-1:0] valid_q;
  logic                 rvalid_q;

  logic             strobe_q, strobe_d;
  logic [3:0]       wreg_q, wreg_d;
  logic [7:0]       wdata_q, wdata_d;
  logic             load_q, load_d;
  logic             err_q, err_d;

  logic [UnitW+2:0] rd_sel;
  logic [UnitW+2:0] wr_sel;
  logic [RamAw-1:0] ram_raddr;
  logic [RamAw-1:0] ram_waddr;
  logic             ram_we;
  logic [7:0]       ram_rdata;
  logic [7:0]       line_rd;
  logic [7:0]       line_new;
  logic             acc;
  logic             cur_bit;
  logic             want;
  logic             cnt_at_end;
  logic             init_last;
  logic             sweep_last;

  lmd_decode #(.UNITS(UNITS)) u_decode (
    .op_i   (op_e'(op_i)),
    .x_i    (x_pos_i),
    .y_i    (y_pos_i),
    .rot_i  (rot_q),
    .cls_o  (dec_cls),
    .plan_o (dec_plan),
    .unit_o (dec_unit)
  );

  lmd_ram #(.WIDTH(8), .DEPTH(LineCount)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (line_new),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lmd_merge #(.UNITS(UNITS)) u_merge (
    .plan_i    (plan_q),
    .target_i  (tu_q),
    .unit_i    (pipe_u_q),
    .digit_i   (pipe_dig_q),
    .pattern_i (pattern_q),
    .old_i     (line_rd),
    .new_o     (line_new)
  );

  assign busy       = (state_q != S_IDLE);
  assign acc        = start && !busy;
  assign line_rd    = rvalid_q ? ram_rdata : 8'h00;
  assign cur_bit    = line_rd[plan_q.bitpos];
  assign cnt_at_end = (cnt_u_q == '0);
  assign init_last  = cnt_at_end && (cnt_d_q == INIT_LAST_STEP);
  assign sweep_last = cnt_at_end && (!plan_q.full || (cnt_d_q == 3'd7));
  assign ram_raddr  = rd_sel[RamAw-1:0];
  assign wr_sel     = {pipe_u_q, pipe_dig_q};

  always_comb begin
    case (op_q)
      OP_ON:   want = 1'b1;
      OP_OFF:  want = 1'b0;
      default: want = ~cur_bit;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (dec_cls)
            CLS_ERR:  state_d = S_ERR;
            CLS_INIT: state_d = S_INIT;
            CLS_PIX:  state_d = S_PEEK;
            default:  state_d = S_SWEEP;
          endcase
        end
      end
      S_ERR:   state_d = S_IDLE;
      S_INIT:  state_d = init_last ? S_IDLE : S_INIT;
      S_PEEK:  state_d = S_TEST;
      S_TEST:  state_d = (cur_bit == want) ? S_IDLE : S_SWEEP;
      S_SWEEP: state_d = sweep_last ? S_DRAIN : S_SWEEP;
      S_DRAIN: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    plan_d     = plan_q;
    tu_d       = tu_q;
    pattern_d  = pattern_q;
    op_d       = op_q;
    cnt_u_d    = cnt_u_q;
    cnt_d_d    = cnt_d_q;
    pipe_vld_d = 1'b0;
    pipe_u_d   = pipe_u_q;
    pipe_dig_d = pipe_dig_q;
    rd_sel     = {cnt_u_q, cnt_d_q};
    strobe_d   = 1'b0;
    wreg_d     = wreg_q;
    wdata_d    = wdata_q;
    load_d     = load_q;
    err_d      = err_q;
    ram_we     = 1'b0;
    ram_waddr  = wr_sel[RamAw-1:0];
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          plan_d    = dec_plan;
          tu_d      = dec_unit;
          pattern_d = pattern_i;
          op_d      = op_e'(op_i);
          cnt_u_d   = UnitW'(UNITS - 1);
          cnt_d_d   = dec_plan.full ? 3'd0 : dec_plan.digit;
        end
      end
      S_ERR: begin
        strobe_d = 1'b1;
        wreg_d   = 4'h0;
        wdata_d  = 8'h00;
        load_d   = 1'b0;
        err_d    = 1'b1;
      end
      S_INIT: begin
        strobe_d = 1'b1;
        wreg_d   = init_reg(cnt_d_q);
        wdata_d  = init_data(cnt_d_q, bright_q);
        load_d   = cnt_at_end;
        err_d    = 1'b0;
        if (cnt_at_end) begin
          cnt_u_d = UnitW'(UNITS - 1);
          cnt_d_d = cnt_d_q + 3'd1;
        end else begin
          cnt_u_d = cnt_u_q - UnitW'(1);
        end
      end
      S_PEEK: begin
        rd_sel = {tu_q, plan_q.digit};
      end
      S_TEST: begin
        plan_d.level = want;
      end
      S_SWEEP: begin
        pipe_vld_d = 1'b1;
        pipe_u_d   = cnt_u_q;
        pipe_dig_d = cnt_d_q;
        if (cnt_at_end) begin
          cnt_u_d = UnitW'(UNITS - 1);
          cnt_d_d = cnt_d_q + 3'd1;
        end else begin
          cnt_u_d = cnt_u_q - UnitW'(1);
        end
      end
      default: begin
      end
    endcase
    if (pipe_vld_q) begin
      ram_we   = 1'b1;
      strobe_d = 1'b1;
      wreg_d   = REG_DIGIT0 + {1'b0, pipe_dig_q};
      wdata_d  = line_new;
      load_d   = (pipe_u_q == '0);
      err_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pipe_vld_q <= 1'b0;
      strobe_q   <= 1'b0;
      valid_q    <= '0;
      rvalid_q   <= 1'b0;
      rot_q      <= 2'd0;
      bright_q   <= BRIGHT_RESET;
    end else begin
      state_q    <= state_d;
      pipe_vld_q <= pipe_vld_d;
      strobe_q   <= strobe_d;
      rvalid_q   <= valid_q[ram_raddr];
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROTATION:   rot_q <= cfg_wdata_i[1:0];
          CFG_BRIGHTNESS: bright_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    plan_q     <= plan_d;
    tu_q       <= tu_d;
    pattern_q  <= pattern_d;
    op_q       <= op_d;
    cnt_u_q    <= cnt_u_d;
    cnt_d_q    <= cnt_d_d;
    pipe_u_q   <= pipe_u_d;
    pipe_dig_q <= pipe_dig_d;
    wreg_q     <= wreg_d;
    wdata_q    <= wdata_d;
    load_q     <= load_d;
    err_q      <= err_d;
  end

  assign strobe_o      = strobe_q;
  assign word_reg_o    = wreg_q;
  assign word_data_o   = wdata_q;
  assign load_after_o  = load_q;
  assign range_error_o = err_q;

endmodule

`default_nettype wire

// ===== verif/lmd_word_checker.sv =====
// Checker for the LED matrix frame driver: keeps its own copy of the frame and the
// configuration, predicts the driver words of every accepted command and compares
// them with the strobed results. Depends on lmd_pkg.
`timescale 1ns / 1ps

module lmd_word_checker import lmd_pkg::*; #(
  parameter int UNITS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        busy_i,
  input  wire logic [2:0]  op_i,
  input  wire logic [4:0]  x_pos_i,
  input  wire logic [4:0]  y_pos_i,
  input  wire logic [31:0] pattern_i,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [3:0]  cfg_wdata_i,
  input  wire logic        strobe_i,
  input  wire logic [3:0]  word_reg_i,
  input  wire logic [7:0]  word_data_i,
  input  wire logic        load_after_i,
  input  wire logic        range_error_i,
  output int unsigned      mismatch_count,
  output int unsigned      words_pending
);

  localparam int LINES = 8 * UNITS;

  typedef struct packed {
    logic [3:0] addr;
    logic [7:0] data;
    logic       load;
    logic       err;
  } drv_word_t;

  logic [7:0]  disp_lines [LINES];
  logic [1:0]  rot;
  logic [3:0]  bright;
  drv_word_t   expected_words [$];
  drv_word_t   want_word;
  int unsigned fails;

  function automatic void push_word(input logic [3:0] addr, input logic [7:0] data,
                                    input logic load, input logic err);
    drv_word_t w;
    w.addr = addr;
    w.data = data;
    w.load = load;
    w.err  = err;
    expected_words.push_back(w);
  endfunction

  // One digit line goes to every unit of the chain, farthest unit first.
  function automatic void push_digit(input int digit);
    for (int u = UNITS - 1; u >= 0; u--) begin
      push_word(REG_DIGIT0 + 4'(digit), disp_lines[u * 8 + digit], u == 0, 1'b0);
    end
  endfunction

  function automatic void push_frame();
    for (int d = 0; d < 8; d++) begin
      push_digit(d);
    end
  endfunction

  function automatic void push_setup(input logic [3:0] addr, input logic [7:0] data);
    for (int u = 0; u < UNITS; u++) begin
      push_word(addr, data, u == UNITS - 1, 1'b0);
    end
  endfunction

  function automatic void map_pixel(input int x, input int y, output int line, output int bpos);
    case (rot)
      2'd0: begin
        line = (x & ~7) + (y & 7);
        bpos = 7 - (x & 7);
      end
      2'd1: begin
        line = ((UNITS - 1 - (y >> 3)) << 3) + (x & 7);
        bpos = y & 7;
      end
      2'd2: begin
        line = ((UNITS - 1 - (x >> 3)) << 3) + (7 - (y & 7));
        bpos = x & 7;
      end
      default: begin
        line = (y & ~7) + (7 - (x & 7));
        bpos = 7 - (y & 7);
      end
    endcase
    line = line % LINES;
  endfunction

  function automatic void paint(input int x, input int y, input logic lit);
    int line, bpos;
    map_pixel(x, y, line, bpos);
    disp_lines[line][bpos] = lit;
  endfunction

  // Pattern positions past bit 31 read as zero.
  function automatic logic pat_bit(input logic [31:0] pat, input int idx);
    return (idx < 32) ? pat[idx] : 1'b0;
  endfunction

  function automatic void predict_driver_words(input op_e op, input int x, input int y,
                                               input logic [31:0] pat);
    int   wid, hgt, line, bpos;
    logic cur, want;
    wid = rot[0] ? 8 : LINES;
    hgt = rot[0] ? LINES : 8;
    case (op)
      OP_INIT: begin
        push_setup(REG_SCANLIMIT, SCAN_ALL);
        push_setup(REG_DECODE, NO_DECODE);
        push_setup(REG_SHUTDOWN, NORMAL_OP);
        push_setup(REG_TEST, TEST_OFF);
        push_setup(REG_INTENSITY, {4'h0, bright});
      end
      OP_ON, OP_OFF, OP_TOGGLE: begin
        if (x >= wid || y >= hgt) begin
          push_word(4'h0, 8'h00, 1'b0, 1'b1);
        end else begin
          map_pixel(x, y, line, bpos);
          cur  = disp_lines[line][bpos];
          want = (op == OP_ON) ? 1'b1 : (op == OP_OFF) ? 1'b0 : !cur;
          if (cur != want) begin
            disp_lines[line][bpos] = want;
            push_digit(line & 7);
          end
        end
      end
      OP_ROW: begin
        if (y >= hgt) begin
          push_word(4'h0, 8'h00, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < wid; i++) begin
            paint(i, y, pat_bit(pat, wid - 1 - i));
          end
          if (!rot[0]) begin
            map_pixel(0, y, line, bpos);
            push_digit(line & 7);
          end else begin
            push_frame();
          end
        end
      end
      OP_COL: begin
        if (x >= wid) begin
          push_word(4'h0, 8'h00, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < hgt; i++) begin
            paint(x, i, pat_bit(pat, hgt - 1 - i));
          end
          if (rot[0]) begin
            map_pixel(x, 0, line, bpos);
            push_digit(line & 7);
          end else begin
            push_frame();
          end
        end
      end
      OP_CLEAR: begin
        foreach (disp_lines[i]) disp_lines[i] = 8'h00;
        push_frame();
      end
      OP_FILL: begin
        foreach (disp_lines[i]) disp_lines[i] = 8'hFF;
        push_frame();
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (disp_lines[i]) disp_lines[i] = 8'h00;
      rot    = 2'd0;
      bright = BRIGHT_RESET;
      expected_words.delete();
      fails = 0;
      mismatch_count <= 0;
      words_pending  <= 0;
    end else begin
      if (strobe_i) begin
        if (expected_words.size() == 0) begin
          $error("word_reg: no word expected, got reg %0d data %0h", word_reg_i, word_data_i);
          fails++;
        end else begin
          want_word = expected_words.pop_front();
          if (word_reg_i !== want_word.addr) begin
            $error("word_reg: expected %0d, got %0d", want_word.addr, word_reg_i);
            fails++;
          end
          if (word_data_i !== want_word.data) begin
            $error("word_data: expected %0h, got %0h", want_word.data, word_data_i);
            fails++;
          end
          if (load_after_i !== want_word.load) begin
            $error("load_after: expected %0b, got %0b", want_word.load, load_after_i);
            fails++;
          end
          if (range_error_i !== want_word.err) begin
            $error("range_error: expected %0b, got %0b", want_word.err, range_error_i);
            fails++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_ROTATION) begin
          rot = cfg_wdata_i[1:0];
        end else begin
          bright = cfg_wdata_i;
        end
      end
      if (start_i && !busy_i) begin
        predict_driver_words(op_e'(op_i), int'(x_pos_i), int'(y_pos_i), pattern_i);
      end
      mismatch_count <= fails;
      words_pending  <= expected_words.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
// Testbench top for led_matrix_frame_driver_unit: clock, reset, directed and random
// commands under several rotations, brightness values and sender gaps, and the verdict.
// Depends on lmd_pkg, the RTL and lmd_word_checker.
`timescale 1ns / 1ps

module tb;
  import lmd_pkg::*;

  localparam int UNITS       = 4;
  localparam int LINES       = 8 * UNITS;
  localparam int DRAIN       = 40;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start       = 1'b0;
  logic [2:0]  op_i        = '0;
  logic [4:0]  x_pos_i     = '0;
  logic [4:0]  y_pos_i     = '0;
  logic [31:0] pattern_i   = '0;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_idx_i   = 1'b0;
  logic [3:0]  cfg_wdata_i = '0;
  logic        busy;
  logic        strobe_o;
  logic [3:0]  word_reg_o;
  logic [7:0]  word_data_o;
  logic        load_after_o;
  logic        range_error_o;

  int unsigned mismatch_count;
  int unsigned words_pending;
  int unsigned cycle_count = 0;
  int          idle_pct    = 0;
  logic [1:0]  rotation    = 2'd0;

  always #5 clk_i = ~clk_i;

  led_matrix_frame_driver_unit #(.UNITS(UNITS)) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .x_pos_i       (x_pos_i),
    .y_pos_i       (y_pos_i),
    .pattern_i     (pattern_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .strobe_o      (strobe_o),
    .word_reg_o    (word_reg_o),
    .word_data_o   (word_data_o),
    .load_after_o  (load_after_o),
    .range_error_o (range_error_o)
  );

  lmd_word_checker #(.UNITS(UNITS)) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .op_i           (op_i),
    .x_pos_i        (x_pos_i),
    .y_pos_i        (y_pos_i),
    .pattern_i      (pattern_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .strobe_i       (strobe_o),
    .word_reg_i     (word_reg_o),
    .word_data_i    (word_data_o),
    .load_after_i   (load_after_o),
    .range_error_i  (range_error_o),
    .mismatch_count (mismatch_count),
    .words_pending  (words_pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("led_matrix_frame_driver_unit test failed");
      $finish;
    end
  end

  // Holds a command until its beat is taken, then idles the sender at random.
  task automatic issue_cmd(input op_e op, input logic [4:0] x, input logic [4:0] y,
                           input logic [31:0] pat);
    start     <= 1'b1;
    op_i      <= op;
    x_pos_i   <= x;
    y_pos_i   <= y;
    pattern_i <= pat;
    do @(posedge clk_i); while (busy);
    while ($urandom_range(99) < idle_pct) begin
      start     <= 1'b0;
      op_i      <= 3'($urandom);
      x_pos_i   <= 5'($urandom);
      y_pos_i   <= 5'($urandom);
      pattern_i <= $urandom;
      @(posedge clk_i);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (words_pending != 0 || busy);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [3:0] rot_word, input logic [3:0] level);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_ROTATION;
    cfg_wdata_i <= rot_word;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_BRIGHTNESS;
    cfg_wdata_i <= level;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    rotation = rot_word[1:0];
  endtask

  task automatic run_random(input int count);
    int          wid, hgt, r;
    op_e         op;
    logic [4:0]  x, y;
    logic [31:0] pat;
    for (int k = 0; k < count; k++) begin
      wid = rotation[0] ? 8 : LINES;
      hgt = rotation[0] ? LINES : 8;
      x   = 5'($urandom_range(wid - 1));
      y   = 5'($urandom_range(hgt - 1));
      if ($urandom_range(99) < 8) begin
        x = 5'($urandom);
        y = 5'($urandom);
      end
      r = $urandom_range(99);
      if (r < 3)       op = OP_INIT;
      else if (r < 18) op = OP_ON;
      else if (r < 30) op = OP_OFF;
      else if (r < 55) op = OP_TOGGLE;
      else if (r < 72) op = OP_ROW;
      else if (r < 89) op = OP_COL;
      else if (r < 94) op = OP_CLEAR;
      else             op = OP_FILL;
      case ($urandom_range(9))
        0:       pat = 32'h0000_0000;
        1:       pat = 32'hFFFF_FFFF;
        default: pat = $urandom;
      endcase
      issue_cmd(op, x, y, pat);
    end
  endtask

  initial begin
    int pct [8];
    pct = '{0, 60, 16, 0, 60, 16, 0, 60};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue_cmd(OP_INIT, 5'd0, 5'd0, 32'h0);
    issue_cmd(OP_ON, 5'd0, 5'd0, 32'h0);
    issue_cmd(OP_ON, 5'd0, 5'd0, 32'h0);
    issue_cmd(OP_ON, 5'd31, 5'd7, 32'h0);
    issue_cmd(OP_TOGGLE, 5'd31, 5'd7, 32'h0);
    issue_cmd(OP_OFF, 5'd31, 5'd7, 32'h0);
    issue_cmd(OP_ON, 5'd31, 5'd8, 32'h0);
    issue_cmd(OP_TOGGLE, 5'd0, 5'd31, 32'h0);
    issue_cmd(OP_ROW, 5'd0, 5'd7, 32'hFFFF_FFFF);
    issue_cmd(OP_ROW, 5'd31, 5'd0, 32'h8000_0001);
    issue_cmd(OP_ROW, 5'd0, 5'd8, 32'h1234_5678);
    issue_cmd(OP_COL, 5'd31, 5'd0, 32'h0000_00A5);
    issue_cmd(OP_COL, 5'd0, 5'd31, 32'hFFFF_FFFF);
    issue_cmd(OP_FILL, 5'd31, 5'd31, 32'hFFFF_FFFF);
    issue_cmd(OP_OFF, 5'd16, 5'd3, 32'h0);
    issue_cmd(OP_CLEAR, 5'd0, 5'd0, 32'h0);
    settle();
    set_config(4'b1101, 4'd15);
    issue_cmd(OP_INIT, 5'd0, 5'd0, 32'h0);
    issue_cmd(OP_COL, 5'd7, 5'd0, 32'hFFFF_FFFF);
    issue_cmd(OP_COL, 5'd8, 5'd0, 32'hFFFF_FFFF);
    issue_cmd(OP_ROW, 5'd0, 5'd31, 32'h0000_005A);
    issue_cmd(OP_ON, 5'd7, 5'd31, 32'h0);
    issue_cmd(OP_ON, 5'd8, 5'd0, 32'h0);
    settle();
    set_config(4'b0010, 4'd0);
    issue_cmd(OP_ON, 5'd0, 5'd0, 32'h0);
    issue_cmd(OP_ROW, 5'd0, 5'd3, 32'hDEAD_BEEF);
    issue_cmd(OP_INIT, 5'd0, 5'd0, 32'h0);

    for (int p = 0; p < 8; p++) begin
      settle();
      set_config({2'($urandom), 2'(p)},
                 (p == 0) ? 4'd0 : (p == 1) ? 4'd15 : 4'($urandom));
      idle_pct = pct[p];
      run_random(51);
    end
    settle();

    if (mismatch_count == 0) begin
      $display("led_matrix_frame_driver_unit test passed");
    end else begin
      $display("led_matrix_frame_driver_unit test failed");
    end
    $finish;
  end

endmodule
